>>> hdl/esc_pkg.sv
// shared types, constants and arithmetic helpers for the sensor compensation pipeline
package esc_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_TEMP      = 3'd0;
	localparam logic [2:0] REG_PRESS_LO  = 3'd1;
	localparam logic [2:0] REG_PRESS_HI  = 3'd2;
	localparam logic [2:0] REG_PRESS_NINE = 3'd3;
	localparam logic [2:0] REG_HUM       = 3'd4;

	localparam int DIV_STEPS = 64;

	localparam logic [63:0] PRESS_BIAS   = 64'h0000_8000_0000_0000;
	localparam logic [63:0] PRESS_FULL   = 64'd1048576;
	localparam logic [63:0] PRESS_SCALE  = 64'd3125;
	localparam logic [63:0] HUM_LIMIT    = 64'd419430400;

	// partial products of a 64 x 64 product, low 64 bits only
	typedef struct packed {
		logic [63:0] lo;
		logic [31:0] mid;
	} pp_t;

	// fields that ride along with the divider
	typedef struct packed {
		logic signed [31:0] tf;
		logic [26:0]        tc;
		logic [16:0]        hum;
		logic               bad;
		logic               neg;
		logic [30:0]        mb;
	} side_t;

	function automatic pp_t mul_pp(logic [63:0] a, logic [63:0] b);
		pp_t r;
		r.lo  = 64'(a[31:0]) * 64'(b[31:0]);
		r.mid = a[31:0] * b[63:32] + a[63:32] * b[31:0];
		return r;
	endfunction

	function automatic logic [63:0] pp_sum(pp_t p);
		return p.lo + {p.mid, 32'b0};
	endfunction

	function automatic logic [63:0] asr(logic [63:0] v, int unsigned n);
		return 64'($signed(v) >>> n);
	endfunction

endpackage

>>> hdl/env_sensor_compensation.sv
// sensor compensation top level: temperature, pressure and humidity pipeline
// throughput: one item per cycle, busy stays low, so start may be high every cycle
// the 64-step pressure divider (one quotient bit per stage) sets most of the latency
// reset: arst_n clears all valid bits and the coefficient registers; no result is pending after it
// done marks each result for exactly one cycle; the receiver cannot stall the pipeline
module env_sensor_compensation (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [19:0]         raw_temperature,
	input  logic [19:0]         raw_pressure,
	input  logic [15:0]         raw_humidity,
	input  logic                cfg_wr_en,
	input  logic [2:0]          cfg_index,
	input  logic [63:0]         cfg_wdata,
	output logic                done,
	output logic signed [31:0]  fine_temperature,
	output logic signed [26:0]  temperature_centi,
	output logic [31:0]         pressure_q24_8,
	output logic                pressure_invalid,
	output logic [16:0]         humidity_q22_10
);

	// coefficient registers
	logic [47:0] temp_q;
	logic [63:0] pl_q;
	logic [63:0] ph_q;
	logic [15:0] p9_q;
	logic [63:0] hum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_q <= '0;
			pl_q   <= '0;
			ph_q   <= '0;
			p9_q   <= '0;
			hum_q  <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				esc_pkg::REG_TEMP:       temp_q <= cfg_wdata[47:0];
				esc_pkg::REG_PRESS_LO:   pl_q   <= cfg_wdata;
				esc_pkg::REG_PRESS_HI:   ph_q   <= cfg_wdata;
				esc_pkg::REG_PRESS_NINE: p9_q   <= cfg_wdata[15:0];
				esc_pkg::REG_HUM:        hum_q  <= cfg_wdata;
				default: ; // writes past the register list are dropped
			endcase
		end
	end

	// coefficient fields, sign extended where the arithmetic is 64 bits wide
	logic [15:0]        t1;
	logic signed [15:0] t2, t3;
	logic [15:0]        p1;
	logic signed [15:0] p2, p5;
	logic [63:0]        p3_w, p4_w, p6_w, p7_w, p8_w, p9_w;
	logic [7:0]         h1, h3;
	logic signed [15:0] h2;
	logic signed [11:0] h4, h5;
	logic signed [7:0]  h6;

	assign t1   = temp_q[15:0];
	assign t2   = temp_q[31:16];
	assign t3   = temp_q[47:32];
	assign p1   = pl_q[15:0];
	assign p2   = pl_q[31:16];
	assign p3_w = {{48{pl_q[47]}}, pl_q[47:32]};
	assign p4_w = {{48{pl_q[63]}}, pl_q[63:48]};
	assign p5   = ph_q[15:0];
	assign p6_w = {{48{ph_q[31]}}, ph_q[31:16]};
	assign p7_w = {{48{ph_q[47]}}, ph_q[47:32]};
	assign p8_w = {{48{ph_q[63]}}, ph_q[63:48]};
	assign p9_w = {{48{p9_q[15]}}, p9_q};
	assign h1   = hum_q[7:0];
	assign h2   = hum_q[23:8];
	assign h3   = hum_q[31:24];
	assign h4   = hum_q[43:32];
	assign h5   = hum_q[55:44];
	assign h6   = hum_q[63:56];

	// every cycle can take a new item
	assign busy = 1'b0;

	// valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;
	logic v_s12, v_s13, v_s14, v_s15, v_s16;
	logic [esc_pkg::DIV_STEPS-1:0] dv_vld_s;

	// stage 1: first temperature term and the squared offset
	logic signed [18:0] c1_dt;
	logic signed [34:0] c1_tp;
	logic signed [16:0] c1_d;
	logic signed [33:0] c1_dd;
	logic signed [23:0] ta_s1;
	logic [31:0]        dsq_s1;
	logic [19:0]        rp_s1;
	logic [15:0]        rh_s1;

	assign c1_dt = $signed({2'b0, raw_temperature[19:3]}) - $signed({2'b0, t1, 1'b0});
	assign c1_tp = c1_dt * t2;
	assign c1_d  = $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, t1});
	assign c1_dd = c1_d * c1_d;

	// stage 2: fine temperature
	logic signed [36:0] c2_bp;
	logic signed [31:0] tf_s2;
	logic [19:0]        rp_s2;
	logic [15:0]        rh_s2;

	assign c2_bp = $signed({1'b0, dsq_s1[31:12]}) * t3;

	// stage 3: centi-degrees, small pressure and humidity products
	logic signed [34:0] c3_t5;
	logic signed [24:0] c3_pa, c3_hv;
	logic signed [49:0] c3_sq;
	logic signed [40:0] c3_ap5, c3_ap2;
	logic signed [36:0] c3_h5v;
	logic signed [38:0] c3_hi;
	logic signed [32:0] c3_h6v;
	logic signed [33:0] c3_h3v;
	logic signed [31:0] tf_s3;
	logic signed [26:0] tc_s3;
	logic signed [47:0] asq_s3;
	logic signed [40:0] ap5_s3, ap2_s3;
	logic [19:0]        rp_s3;
	logic signed [23:0] hx_s3, hd1_s3, hd2_s3;

	assign c3_t5  = 35'(tf_s2) * 35'sd5 + 35'sd128;
	assign c3_pa  = 25'(tf_s2) - 25'sd128000;
	assign c3_hv  = 25'(tf_s2) - 25'sd76800;
	assign c3_sq  = c3_pa * c3_pa;
	assign c3_ap5 = c3_pa * p5;
	assign c3_ap2 = c3_pa * p2;
	assign c3_h5v = c3_hv * h5;
	assign c3_hi  = $signed({9'b0, rh_s2, 14'b0}) - (39'(h4) <<< 20) - 39'(c3_h5v)
		+ 39'sd16384;
	assign c3_h6v = c3_hv * h6;
	assign c3_h3v = c3_hv * $signed({1'b0, h3});

	// stage 4: wide pressure products split into partial products
	esc_pkg::pp_t       pp6_s4, pp3_s4;
	logic signed [47:0] c4_m;
	logic signed [31:0] tf_s4;
	logic signed [26:0] tc_s4;
	logic signed [40:0] ap5_s4, ap2_s4;
	logic [19:0]        rp_s4;
	logic signed [23:0] hx_s4;
	logic signed [31:0] hd_s4;
	logic [63:0]        asq_w;

	assign asq_w = {{16{asq_s3[47]}}, asq_s3};
	assign c4_m  = hd1_s3 * hd2_s3;

	// stage 5: dividend offset term and divisor base
	logic [63:0]        c5_b, c5_a;
	logic signed [47:0] c5_m;
	logic signed [31:0] tf_s5;
	logic signed [26:0] tc_s5;
	logic [63:0]        pb_s5, a47_s5;
	logic [19:0]        rp_s5;
	logic signed [23:0] hx_s5;
	logic signed [33:0] hf_s5;

	assign c5_b = esc_pkg::pp_sum(pp6_s4) + ({{23{ap5_s4[40]}}, ap5_s4} << 17) + (p4_w << 35);
	assign c5_a = esc_pkg::asr(esc_pkg::pp_sum(pp3_s4), 8)
		+ ({{23{ap2_s4[40]}}, ap2_s4} << 12);
	assign c5_m = hd_s4 * h2;

	// stage 6: divisor product, dividend before scaling, humidity product
	logic [63:0]        c6_p;
	esc_pkg::pp_t       pp1_s6, hpp_s6;
	logic signed [31:0] tf_s6;
	logic signed [26:0] tc_s6;
	logic [63:0]        num0_s6;

	assign c6_p = esc_pkg::PRESS_FULL - {44'b0, rp_s5};

	// stage 7: divisor and scaled dividend
	logic [63:0]        c7_a;
	logic signed [31:0] den_s7;
	esc_pkg::pp_t       ppn_s7;
	logic signed [31:0] tf_s7;
	logic signed [26:0] tc_s7;
	logic [63:0]        hprod_s7;
	logic [63:0]        c8_x;

	assign c7_a = esc_pkg::asr(esc_pkg::pp_sum(pp1_s6), 33);
	assign c8_x = esc_pkg::asr(hprod_s7, 15);

	// stage 8
	logic [63:0]        num_s8;
	logic signed [31:0] den_s8;
	esc_pkg::pp_t       hsq_pp_s8;
	logic signed [31:0] tf_s8;
	logic signed [26:0] tc_s8;
	logic [63:0]        hprod_s8;

	// stage 9: sign and magnitudes for the divider
	logic [31:0]        c9_mb;
	logic [63:0]        ma_s9, hsq_s9, hprod_s9;
	logic [30:0]        mb_s9;
	logic               neg_s9, bad_s9;
	logic signed [31:0] tf_s9;
	logic signed [26:0] tc_s9;

	assign c9_mb = den_s8[31] ? 32'(-den_s8) : 32'(den_s8);

	// stage 10
	esc_pkg::pp_t       hpp1_s10;
	logic [63:0]        ma_s10, hprod_s10;
	logic [30:0]        mb_s10;
	logic               neg_s10, bad_s10;
	logic signed [31:0] tf_s10;
	logic signed [26:0] tc_s10;

	// stage 11: humidity clamp
	logic [63:0]        c11_v, c11_c;
	logic [63:0]        ma_s11;
	esc_pkg::side_t     sd_s11;

	assign c11_v = hprod_s10 - esc_pkg::asr(esc_pkg::pp_sum(hpp1_s10), 4);
	always_comb begin
		c11_c = c11_v;
		if (c11_v[63]) begin
			c11_c = '0;
		end else if (c11_v > esc_pkg::HUM_LIMIT) begin
			c11_c = esc_pkg::HUM_LIMIT;
		end
	end

	// restoring divider, one quotient bit per stage
	logic [30:0]    dv_rem_s [esc_pkg::DIV_STEPS];
	logic [63:0]    dv_q_s   [esc_pkg::DIV_STEPS];
	esc_pkg::side_t dv_sd_s  [esc_pkg::DIV_STEPS];

	for (genvar k = 0; k < esc_pkg::DIV_STEPS; k++) begin : g_div
		logic           vin;
		logic [30:0]    rin;
		logic [63:0]    qin;
		esc_pkg::side_t sin;
		logic [30:0]    trial;
		logic           ge;

		if (k == 0) begin : g_first
			assign vin = v_s11;
			assign rin = '0;
			assign qin = ma_s11;
			assign sin = sd_s11;
		end else begin : g_next
			assign vin = dv_vld_s[k-1];
			assign rin = dv_rem_s[k-1];
			assign qin = dv_q_s[k-1];
			assign sin = dv_sd_s[k-1];
		end

		assign trial = {rin[29:0], qin[63]};
		assign ge    = trial >= sin.mb;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[k] <= 1'b0;
			end else begin
				dv_vld_s[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			dv_rem_s[k] <= ge ? trial - sin.mb : trial;
			dv_q_s[k]   <= {qin[62:0], ge};
			dv_sd_s[k]  <= sin;
		end
	end

	// stage 12: signed quotient
	logic [63:0]    q_last;
	esc_pkg::side_t sd_last;
	logic [63:0]    p_s12;
	esc_pkg::side_t sd_s12;

	assign q_last  = dv_q_s[esc_pkg::DIV_STEPS-1];
	assign sd_last = dv_sd_s[esc_pkg::DIV_STEPS-1];

	// stage 13: correction products
	logic [63:0]    c13_t;
	esc_pkg::pp_t   pp9_s13, pp8_s13;
	logic [63:0]    p_s13, t_s13;
	esc_pkg::side_t sd_s13;

	assign c13_t = esc_pkg::asr(p_s12, 13);

	// stage 14
	logic [63:0]    y_s14, b8_s14, p_s14, t_s14;
	esc_pkg::side_t sd_s14;

	// stage 15
	esc_pkg::pp_t   ppy_s15;
	logic [63:0]    b8_s15, p_s15;
	esc_pkg::side_t sd_s15;

	// stage 16: final pressure and output registers
	logic [63:0]        c16_p;
	logic signed [31:0] tf_s16;
	logic signed [26:0] tc_s16;
	logic [31:0]        pr_s16;
	logic               bad_s16;
	logic [16:0]        hum_s16;

	assign c16_p = esc_pkg::asr(p_s15 + esc_pkg::asr(esc_pkg::pp_sum(ppy_s15), 25) + b8_s15, 8)
		+ (p7_w << 4);

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
			v_s15 <= 1'b0;
			v_s16 <= 1'b0;
		end else begin
			v_s1  <= start && !busy;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= dv_vld_s[esc_pkg::DIV_STEPS-1];
			v_s13 <= v_s12;
			v_s14 <= v_s13;
			v_s15 <= v_s14;
			v_s16 <= v_s15;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		// stage 1
		ta_s1  <= 24'(c1_tp >>> 11);
		dsq_s1 <= 32'(c1_dd);
		rp_s1  <= raw_pressure;
		rh_s1  <= raw_humidity;
		// stage 2
		tf_s2 <= 32'(ta_s1) + 32'(c2_bp >>> 14);
		rp_s2 <= rp_s1;
		rh_s2 <= rh_s1;
		// stage 3
		tf_s3  <= tf_s2;
		tc_s3  <= 27'(c3_t5 >>> 8);
		asq_s3 <= 48'(c3_sq);
		ap5_s3 <= c3_ap5;
		ap2_s3 <= c3_ap2;
		rp_s3  <= rp_s2;
		hx_s3  <= 24'(c3_hi >>> 15);
		hd1_s3 <= 24'(c3_h6v >>> 10);
		hd2_s3 <= 24'(c3_h3v >>> 11) + 24'sd32768;
		// stage 4
		pp6_s4 <= esc_pkg::mul_pp(asq_w, p6_w);
		pp3_s4 <= esc_pkg::mul_pp(asq_w, p3_w);
		tf_s4  <= tf_s3;
		tc_s4  <= tc_s3;
		ap5_s4 <= ap5_s3;
		ap2_s4 <= ap2_s3;
		rp_s4  <= rp_s3;
		hx_s4  <= hx_s3;
		hd_s4  <= 32'(c4_m >>> 10) + 32'sd2097152;
		// stage 5
		tf_s5  <= tf_s4;
		tc_s5  <= tc_s4;
		pb_s5  <= c5_b;
		a47_s5 <= esc_pkg::PRESS_BIAS + c5_a;
		rp_s5  <= rp_s4;
		hx_s5  <= hx_s4;
		hf_s5  <= 34'((c5_m + 48'sd8192) >>> 14);
		// stage 6
		pp1_s6  <= esc_pkg::mul_pp(a47_s5, {48'b0, p1});
		num0_s6 <= (c6_p << 31) - pb_s5;
		hpp_s6  <= esc_pkg::mul_pp({{40{hx_s5[23]}}, hx_s5}, {{30{hf_s5[33]}}, hf_s5});
		tf_s6   <= tf_s5;
		tc_s6   <= tc_s5;
		// stage 7
		den_s7   <= c7_a[31:0];
		ppn_s7   <= esc_pkg::mul_pp(num0_s6, esc_pkg::PRESS_SCALE);
		hprod_s7 <= esc_pkg::pp_sum(hpp_s6);
		tf_s7    <= tf_s6;
		tc_s7    <= tc_s6;
		// stage 8
		num_s8    <= esc_pkg::pp_sum(ppn_s7);
		den_s8    <= den_s7;
		hsq_pp_s8 <= esc_pkg::mul_pp(c8_x, c8_x);
		hprod_s8  <= hprod_s7;
		tf_s8     <= tf_s7;
		tc_s8     <= tc_s7;
		// stage 9
		ma_s9    <= num_s8[63] ? 64'(-num_s8) : num_s8;
		mb_s9    <= c9_mb[30:0];
		neg_s9   <= num_s8[63] ^ den_s8[31];
		bad_s9   <= den_s8 == 32'sd0;
		hsq_s9   <= esc_pkg::pp_sum(hsq_pp_s8);
		hprod_s9 <= hprod_s8;
		tf_s9    <= tf_s8;
		tc_s9    <= tc_s8;
		// stage 10
		hpp1_s10  <= esc_pkg::mul_pp(esc_pkg::asr(hsq_s9, 7), {56'b0, h1});
		hprod_s10 <= hprod_s9;
		ma_s10    <= ma_s9;
		mb_s10    <= mb_s9;
		neg_s10   <= neg_s9;
		bad_s10   <= bad_s9;
		tf_s10    <= tf_s9;
		tc_s10    <= tc_s9;
		// stage 11
		ma_s11     <= ma_s10;
		sd_s11.tf  <= tf_s10;
		sd_s11.tc  <= tc_s10;
		sd_s11.hum <= c11_c[28:12];
		sd_s11.bad <= bad_s10;
		sd_s11.neg <= neg_s10;
		sd_s11.mb  <= mb_s10;
		// stage 12
		p_s12  <= sd_last.neg ? 64'(-q_last) : q_last;
		sd_s12 <= sd_last;
		// stage 13
		pp9_s13 <= esc_pkg::mul_pp(p9_w, c13_t);
		pp8_s13 <= esc_pkg::mul_pp(p8_w, p_s12);
		p_s13   <= p_s12;
		t_s13   <= c13_t;
		sd_s13  <= sd_s12;
		// stage 14
		y_s14  <= esc_pkg::pp_sum(pp9_s13);
		b8_s14 <= esc_pkg::asr(esc_pkg::pp_sum(pp8_s13), 19);
		p_s14  <= p_s13;
		t_s14  <= t_s13;
		sd_s14 <= sd_s13;
		// stage 15
		ppy_s15 <= esc_pkg::mul_pp(y_s14, t_s14);
		b8_s15  <= b8_s14;
		p_s15   <= p_s14;
		sd_s15  <= sd_s14;
		// stage 16: a zero divisor forces pressure to zero
		tf_s16  <= sd_s15.tf;
		tc_s16  <= sd_s15.tc;
		pr_s16  <= sd_s15.bad ? 32'd0 : c16_p[31:0];
		bad_s16 <= sd_s15.bad;
		hum_s16 <= sd_s15.hum;
	end

	assign done              = v_s16;
	assign fine_temperature  = tf_s16;
	assign temperature_centi = tc_s16;
	assign pressure_q24_8    = pr_s16;
	assign pressure_invalid  = bad_s16;
	assign humidity_q22_10   = hum_s16;

	// every start transfer yields a result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##80 done)
		else $error("result missing after start transfer");

	// a flagged pressure is zero
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && pressure_invalid |-> pressure_q24_8 == 32'd0)
		else $error("flagged pressure not zero");

	// humidity stays within 100 percent
	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> humidity_q22_10 <= 17'd102400)
		else $error("humidity out of range");

	// divider remainder ends below a nonzero divisor
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		dv_vld_s[esc_pkg::DIV_STEPS-1] && sd_last.mb != 31'd0
		|-> dv_rem_s[esc_pkg::DIV_STEPS-1] < sd_last.mb)
		else $error("divider remainder not reduced");

endmodule
